// File: rtl/core/pdsnk_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the PD sink message engine.
package pdsnk_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned VOLT_W          = 10;
  localparam int unsigned CUR_W           = 10;
  localparam int unsigned CNT_W           = 3;
  localparam int unsigned REV_W           = 2;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 10;
  localparam int unsigned MAX_OBJECTS_DEF = 7;

  // result queue
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = 2;
  localparam int unsigned RQ_CNT_W = 3;

  localparam logic [VOLT_W-1:0] MIN_VOLTAGE_RST   = 10'd260;
  localparam logic [REV_W-1:0]  SPEC_REVISION_RST = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOLTAGE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEC_REVISION = 2'd1;

  localparam logic [3:0] MSG_SRC_CAPS    = 4'b0001;
  localparam logic [3:0] MSG_REQUEST     = 4'b0010;
  localparam logic [3:0] MSG_PS_RDY      = 4'b0110;
  localparam logic [3:0] MSG_GET_SRC_CAP = 4'b0111;
  localparam logic [3:0] MSG_SOFT_RESET  = 4'b1101;

  localparam logic [1:0] PDO_RESERVED = 2'b11;

  typedef enum logic [1:0] {
    FuncRxHeader  = 2'd0,
    FuncRxObject  = 2'd1,
    FuncGetCaps   = 2'd2,
    FuncSoftReset = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [WORD_W-1:0] rx_word;
  } item_t;

  typedef struct packed {
    logic              is_tx;
    logic [WORD_W-1:0] tx_word;
    logic              tx_last;
    logic              power_enable;
    logic              selection_ok;
  } res_t;

  // up to two result words per item
  typedef struct packed {
    logic one;
    logic two;
    res_t r0;
    res_t r1;
  } push_t;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  function automatic logic [WORD_W-1:0] make_header(
    input logic [3:0]       msg,
    input logic [REV_W-1:0] rev,
    input logic [CNT_W-1:0] id,
    input logic [CNT_W-1:0] count
  );
    return {16'h0000, 1'b0, count, id, 1'b0, rev, 2'b00, msg};
  endfunction

  function automatic logic [WORD_W-1:0] make_rdo(
    input logic [CUR_W-1:0] cur,
    input logic [CNT_W-1:0] pos
  );
    return {1'b0, pos, 8'h00, cur, cur};
  endfunction

endpackage

// File: rtl/core/pdsnk_cmd_if.sv
`timescale 1ns / 1ps
// Input channel: received PD words and commands.
interface pdsnk_cmd_if import pdsnk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [WORD_W-1:0] rx_word;

  modport source (output valid, func, rx_word, input ready);
  modport sink   (input valid, func, rx_word, output ready);
endinterface

// File: rtl/core/pdsnk_rsp_if.sv
`timescale 1ns / 1ps
// Output channel: transmit words and status.
interface pdsnk_rsp_if import pdsnk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_tx;
  logic [WORD_W-1:0] tx_word;
  logic              tx_last;
  logic              power_enable;
  logic              selection_ok;

  modport source (output valid, is_tx, tx_word, tx_last, power_enable, selection_ok,
                  input ready);
  modport sink   (input valid, is_tx, tx_word, tx_last, power_enable, selection_ok,
                  output ready);
endinterface

// File: rtl/core/pdsnk_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel.
interface pdsnk_cfg_if import pdsnk_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/pd_sink_caps_select_request.sv
`timescale 1ns / 1ps
// USB PD sink message engine. Each accepted word (received header, received data
// object, get-source-caps or soft-reset command) is registered, then processed
// against the scan state, and its result words (none, one, or two for the last PDO
// of a Source_Capabilities message) go into a four-entry result queue. A word goes
// through the input register, then the queue, before its first result word shows.
// A new word is accepted every cycle while the queue has two free entries; the
// output port moves one word per cycle while ready is high, so at steady state items
// that raise a Request are paced by it. Configuration writes are always taken.
module pd_sink_caps_select_request import pdsnk_pkg::*; #(
  parameter int unsigned MAX_OBJECTS = MAX_OBJECTS_DEF
) (
  input logic         clk,
  input logic         rst,
  pdsnk_cmd_if.sink   cmd,
  pdsnk_rsp_if.source rsp,
  pdsnk_cfg_if.sink   cfg
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    fire;
  logic    room;
  push_t   push;
  res_t    res;
  cfg_wr_t cfg_wr;

  assign in_item = '{func: cmd.func, rx_word: cmd.rx_word};
  assign fire    = item_valid && room;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = '{en: cfg.valid, index: cfg.index, data: cfg.data};

  pdsnk_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_item  (in_item),
    .in_ready (cmd.ready),
    .take     (fire),
    .valid    (item_valid),
    .item     (item)
  );

  pdsnk_engine #(.MAX_OBJECTS(MAX_OBJECTS)) u_eng (
    .clk    (clk),
    .rst    (rst),
    .cfg_wr (cfg_wr),
    .item   (item),
    .fire   (fire),
    .push   (push)
  );

  pdsnk_out_queue u_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .valid (rsp.valid),
    .data  (res),
    .ready (rsp.ready)
  );

  assign rsp.is_tx        = res.is_tx;
  assign rsp.tx_word      = res.tx_word;
  assign rsp.tx_last      = res.tx_last;
  assign rsp.power_enable = res.power_enable;
  assign rsp.selection_ok = res.selection_ok;

endmodule

// File: rtl/core/pdsnk_in_stage.sv
`timescale 1ns / 1ps
// Input register stage: holds one accepted word until the engine takes it.
module pdsnk_in_stage import pdsnk_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_ready,
  input  logic  take,
  output logic  valid,
  output item_t item
);

  assign in_ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// File: rtl/core/pdsnk_engine.sv
`timescale 1ns / 1ps
// Message engine: scan state, PDO selection, header and request building.
module pdsnk_engine import pdsnk_pkg::*; #(
  parameter int unsigned MAX_OBJECTS = MAX_OBJECTS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg_wr,
  input  item_t   item,
  input  logic    fire,
  output push_t   push
);

  logic [VOLT_W-1:0] min_voltage;
  logic [REV_W-1:0]  hdr_revision;

  logic [CNT_W-1:0]  msg_seq,       msg_seq_next;
  logic [CNT_W-1:0]  objects_left,  objects_left_next;
  logic [CNT_W-1:0]  object_index,  object_index_next;
  logic              in_caps,       in_caps_next;
  logic [VOLT_W-1:0] best_voltage,  best_voltage_next;
  logic [CUR_W-1:0]  best_current,  best_current_next;
  logic [CNT_W-1:0]  best_position, best_position_next;
  logic              found_flag,    found_flag_next;
  logic [CUR_W-1:0]  first_current, first_current_next;
  logic              power_on,      power_on_next;

  func_t             func;
  logic [3:0]        msg;
  logic [CNT_W-1:0]  count;
  logic [1:0]        ptype;
  logic [VOLT_W-1:0] volts;
  logic [CUR_W-1:0]  cur;
  logic              better;
  logic [CUR_W-1:0]  req_cur;
  logic [CNT_W-1:0]  req_pos;

  localparam logic [CNT_W-1:0] MaxObj = CNT_W'(MAX_OBJECTS);

  assign func  = func_t'(item.func);
  assign msg   = item.rx_word[3:0];
  assign count = item.rx_word[14:12];
  assign ptype = item.rx_word[31:30];
  assign volts = item.rx_word[19:10];
  assign cur   = item.rx_word[9:0];

  // non-reserved PDO, strict improvement over the best so far, at or above threshold
  assign better = (ptype != PDO_RESERVED) && (volts >= min_voltage) &&
                  (volts > best_voltage);

  assign req_cur = found_flag_next ? best_current_next  : first_current_next;
  assign req_pos = found_flag_next ? best_position_next : CNT_W'(1);

  always_comb begin
    msg_seq_next       = msg_seq;
    objects_left_next  = objects_left;
    object_index_next  = object_index;
    in_caps_next       = in_caps;
    best_voltage_next  = best_voltage;
    best_current_next  = best_current;
    best_position_next = best_position;
    found_flag_next    = found_flag;
    first_current_next = first_current;
    power_on_next      = power_on;
    push               = '0;

    unique case (func)
      FuncRxHeader: begin
        if (count == '0) begin
          if (msg == MSG_PS_RDY) begin
            power_on_next = 1'b1;
            push.one      = 1'b1;
            push.r0       = '{is_tx: 1'b0, tx_word: '0, tx_last: 1'b0,
                              power_enable: 1'b1, selection_ok: found_flag};
          end
        end else if (msg == MSG_SRC_CAPS) begin
          in_caps_next       = 1'b1;
          objects_left_next  = (count > MaxObj) ? MaxObj : count;
          object_index_next  = '0;
          best_voltage_next  = '0;
          best_current_next  = '0;
          best_position_next = '0;
          found_flag_next    = 1'b0;
          first_current_next = '0;
        end else begin
          in_caps_next      = 1'b0;
          objects_left_next = '0;
        end
      end
      FuncRxObject: begin
        if (in_caps && objects_left != '0) begin
          if (object_index == '0) begin
            first_current_next = cur;
          end
          if (better) begin
            best_voltage_next  = volts;
            best_current_next  = cur;
            best_position_next = object_index + CNT_W'(1);
            found_flag_next    = 1'b1;
          end
          object_index_next = object_index + CNT_W'(1);
          objects_left_next = objects_left - CNT_W'(1);
          // last PDO: header word then request object
          if (objects_left == CNT_W'(1)) begin
            in_caps_next = 1'b0;
            msg_seq_next = msg_seq + CNT_W'(1);
            push.one     = 1'b1;
            push.two     = 1'b1;
            push.r0 = '{is_tx: 1'b1,
                        tx_word: make_header(MSG_REQUEST, hdr_revision, msg_seq,
                                             CNT_W'(1)),
                        tx_last: 1'b0, power_enable: power_on,
                        selection_ok: found_flag_next};
            push.r1 = '{is_tx: 1'b1, tx_word: make_rdo(req_cur, req_pos),
                        tx_last: 1'b1, power_enable: power_on,
                        selection_ok: found_flag_next};
          end
        end
      end
      FuncGetCaps: begin
        msg_seq_next = msg_seq + CNT_W'(1);
        push.one     = 1'b1;
        push.r0 = '{is_tx: 1'b1,
                    tx_word: make_header(MSG_GET_SRC_CAP, hdr_revision, msg_seq, '0),
                    tx_last: 1'b1, power_enable: power_on, selection_ok: found_flag};
      end
      FuncSoftReset: begin
        msg_seq_next = '0;
        push.one     = 1'b1;
        push.r0 = '{is_tx: 1'b1,
                    tx_word: make_header(MSG_SOFT_RESET, hdr_revision, msg_seq, '0),
                    tx_last: 1'b1, power_enable: power_on, selection_ok: found_flag};
      end
      default: begin
      end
    endcase

    // words go to the queue only when the item is actually consumed
    if (!fire) begin
      push = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_voltage  <= MIN_VOLTAGE_RST;
      hdr_revision <= SPEC_REVISION_RST;
    end else if (cfg_wr.en) begin
      if (cfg_wr.index == CFG_MIN_VOLTAGE) begin
        min_voltage <= cfg_wr.data;
      end else if (cfg_wr.index == CFG_SPEC_REVISION) begin
        hdr_revision <= cfg_wr.data[REV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_seq       <= '0;
      objects_left  <= '0;
      object_index  <= '0;
      in_caps       <= 1'b0;
      best_voltage  <= '0;
      best_current  <= '0;
      best_position <= '0;
      found_flag    <= 1'b0;
      first_current <= '0;
      power_on      <= 1'b0;
    end else if (fire) begin
      msg_seq       <= msg_seq_next;
      objects_left  <= objects_left_next;
      object_index  <= object_index_next;
      in_caps       <= in_caps_next;
      best_voltage  <= best_voltage_next;
      best_current  <= best_current_next;
      best_position <= best_position_next;
      found_flag    <= found_flag_next;
      first_current <= first_current_next;
      power_on      <= power_on_next;
    end
  end

endmodule

// File: rtl/core/pdsnk_out_queue.sv
`timescale 1ns / 1ps
// Result queue: takes up to two words per cycle, hands out one while ready is high.
module pdsnk_out_queue import pdsnk_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  valid,
  output res_t  data,
  input  logic  ready
);

  res_t                mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wptr, wptr_next;
  logic [RQ_PTR_W-1:0] rptr, rptr_next;
  logic [RQ_CNT_W-1:0] count, count_next;
  logic                pop;

  assign valid = (count != '0);
  assign data  = mem[rptr];
  assign pop   = valid && ready;
  // engine may only fire when two slots are free
  assign room  = (count <= RQ_CNT_W'(RQ_DEPTH - 2));

  always_comb begin
    wptr_next  = wptr + RQ_PTR_W'(push.one) + RQ_PTR_W'(push.two);
    rptr_next  = rptr + RQ_PTR_W'(pop);
    count_next = count + RQ_CNT_W'(push.one) + RQ_CNT_W'(push.two) - RQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr_next;
      rptr  <= rptr_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.one) begin
      mem[wptr] <= push.r0;
    end
    if (push.two) begin
      mem[wptr + RQ_PTR_W'(1)] <= push.r1;
    end
  end

endmodule

// File: rtl/core/pdsnk_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the PD sink message engine, bound to the top level.
module pdsnk_checker import pdsnk_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              is_tx,
  input logic [WORD_W-1:0] tx_word,
  input logic              tx_last,
  input logic              power_enable
);

  // a pending word is not withdrawn
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result word dropped while stalled");

  // status-only words come from PS_RDY alone
  a_status_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !is_tx |-> tx_word == '0 && !tx_last && power_enable)
    else $error("malformed status word");

  // only a Request header is followed by another word of the same message
  a_multi_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_tx && !tx_last |->
      tx_word[3:0] == MSG_REQUEST && tx_word[31:16] == '0 && tx_word[14:12] == 3'd1)
    else $error("non-last word is not a Request header");

  // power enable never drops once delivered
  a_power_sticky: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !$past(rst) && $past(rsp_valid && rsp_ready && power_enable)
      |-> power_enable)
    else $error("power_enable fell");

endmodule

bind pd_sink_caps_select_request pdsnk_checker u_pdsnk_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .is_tx        (rsp.is_tx),
  .tx_word      (rsp.tx_word),
  .tx_last      (rsp.tx_last),
  .power_enable (rsp.power_enable)
);
